[rtl/core/hfve_pkg.sv]
// Shared types, constants and helpers for the header field value extractor.
package hfve_pkg;

    localparam int MAX_NAME_LEN = 16;
    localparam int LINE_LIMIT   = 1024;
    localparam int LINE_POS_W   = $clog2(LINE_LIMIT + 1);
    localparam int NAME_IDX_W   = $clog2(MAX_NAME_LEN);
    localparam int NAME_LEN_W   = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [5:0] {
        PH_LINE_START = 6'b000001,
        PH_MATCH      = 6'b000010,
        PH_AFTER_NAME = 6'b000100,
        PH_SKIP_WS    = 6'b001000,
        PH_VALUE      = 6'b010000,
        PH_SKIP_LINE  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
    endfunction

endpackage

[rtl/core/header_field_value_extractor.sv]
// Header field value extractor: byte-stream name matcher with value output queue.
//
// Input channel (in_valid/in_stall): one header byte per transaction, with
// message_end marking the last byte of a message. Output channel
// (out_valid/out_stall): one result per transaction; out_kind tells a value
// byte, value complete (found) or header not found.
// Each accepted byte updates the match state in the same cycle and pushes
// zero, one or two results into a four-entry output queue. Each result is
// registered in the queue before it shows on the output.
// Throughput is one byte per cycle while in_stall is low. in_stall rises
// only when the queue holds more than two results, so it follows a stalled
// output; the last byte of a message may produce two results.
// After the found or not-found result of a message, the remaining bytes of
// that message produce nothing; state is cleared after the message_end byte.
// Configuration (cfg_write/cfg_index/cfg_data) is to be written by the user
// while idle; the block does not enforce it. Index 0 name length, 1 name
// characters 0-7, 2 name characters 8-15. Reset clears the queue and the
// search state and sets the name length to 1 with all-zero name characters.
module header_field_value_extractor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [hfve_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hfve_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           message_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     out_kind,
    output logic [7:0]                     out_byte
);
    import hfve_pkg::*;

    logic [NAME_LEN_W-1:0]   name_length_reg;
    logic [CFG_DATA_W-1:0]   name_low_reg;
    logic [CFG_DATA_W-1:0]   name_high_reg;

    phase_t                  phase_reg, phase_next;
    logic [NAME_LEN_W-1:0]   match_pos_reg, match_pos_next;
    logic [LINE_POS_W-1:0]   line_pos_reg, line_pos_next;
    logic [7:0]              prev_byte_reg, prev_byte_next;
    logic                    finished_reg, finished_next;

    result_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    logic                    accept, pop;
    logic                    emit_byte, emit_final;
    logic [1:0]              final_kind;
    logic [1:0]              push_cnt;
    result_t                 res0, res1;

    logic [NAME_LEN_W-1:0]   eff_len;
    logic [2*CFG_DATA_W-1:0] name_all;
    logic [NAME_LEN_W-1:0]   mp_base;
    logic [NAME_LEN_W-1:0]   mp_inc;
    logic [7:0]              name_ch;
    logic                    is_term;

    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign in_stall  = (count_reg > FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_kind  = fifo_reg[rd_ptr_reg].kind;
    assign out_byte  = fifo_reg[rd_ptr_reg].data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= NAME_LEN_W'(1);
            name_low_reg    <= '0;
            name_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NAME_LENGTH: name_length_reg <= cfg_data[NAME_LEN_W-1:0];
                REG_NAME_LOW:    name_low_reg    <= cfg_data;
                REG_NAME_HIGH:   name_high_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (name_length_reg == '0)
            eff_len = NAME_LEN_W'(1);
        else if (name_length_reg > NAME_LEN_W'(MAX_NAME_LEN))
            eff_len = NAME_LEN_W'(MAX_NAME_LEN);
        else
            eff_len = name_length_reg;
    end

    assign name_all = {name_high_reg, name_low_reg};
    // a fresh line restarts the compare at character 0
    assign mp_base  = (phase_reg == PH_LINE_START) ? '0 : match_pos_reg;
    assign mp_inc   = mp_base + NAME_LEN_W'(1);
    assign name_ch  = name_all[{mp_base[NAME_IDX_W-1:0], 3'b000} +: 8];
    assign is_term  = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);

    always_comb
    begin
        phase_next     = phase_reg;
        match_pos_next = match_pos_reg;
        line_pos_next  = line_pos_reg;
        finished_next  = finished_reg;
        prev_byte_next = in_byte;
        emit_byte      = 1'b0;
        emit_final     = 1'b0;
        final_kind     = KIND_NOT_FOUND;

        if (!finished_reg)
        begin
            if (is_term)
            begin
                if ((in_byte == CHAR_LF) && (prev_byte_reg == CHAR_CR))
                begin
                    // LF of a CR LF pair: break already handled
                end
                else if ((phase_reg == PH_LINE_START) && (line_pos_reg == '0))
                begin
                    emit_final    = 1'b1;
                    final_kind    = KIND_NOT_FOUND;
                    finished_next = 1'b1;
                end
                else if ((phase_reg == PH_SKIP_WS) || (phase_reg == PH_VALUE))
                begin
                    emit_final    = 1'b1;
                    final_kind    = KIND_FOUND;
                    finished_next = 1'b1;
                end
                else
                begin
                    phase_next     = PH_LINE_START;
                    match_pos_next = '0;
                    line_pos_next  = '0;
                end
            end
            else
            begin
                if (line_pos_reg < LINE_POS_W'(LINE_LIMIT))
                    line_pos_next = line_pos_reg + LINE_POS_W'(1);
                case (phase_reg)
                    PH_LINE_START, PH_MATCH:
                    begin
                        if ((phase_reg == PH_LINE_START) && is_blank(in_byte))
                        begin
                            // leading blank
                        end
                        else if (fold_case(in_byte) == fold_case(name_ch))
                        begin
                            match_pos_next = mp_inc;
                            phase_next = (mp_inc >= eff_len) ? PH_AFTER_NAME : PH_MATCH;
                        end
                        else
                        begin
                            match_pos_next = mp_base;
                            phase_next     = PH_SKIP_LINE;
                        end
                    end
                    PH_AFTER_NAME:
                    begin
                        phase_next = ((in_byte == CHAR_COLON) || is_blank(in_byte)) ?
                                     PH_SKIP_WS : PH_SKIP_LINE;
                    end
                    PH_SKIP_WS, PH_VALUE:
                    begin
                        if ((phase_reg == PH_SKIP_WS) && is_blank(in_byte))
                        begin
                            // blank before the value
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                            emit_byte  = (line_pos_reg < LINE_POS_W'(LINE_LIMIT - 1));
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (message_end)
        begin
            if (!finished_next)
            begin
                emit_final = 1'b1;
                final_kind = ((phase_next == PH_SKIP_WS) || (phase_next == PH_VALUE)) ?
                             KIND_FOUND : KIND_NOT_FOUND;
            end
            phase_next     = PH_LINE_START;
            match_pos_next = '0;
            line_pos_next  = '0;
            prev_byte_next = '0;
            finished_next  = 1'b0;
        end
    end

    always_comb
    begin
        res0 = '{kind: final_kind, data: 8'h00};
        res1 = '{kind: final_kind, data: 8'h00};
        if (emit_byte)
            res0 = '{kind: KIND_BYTE, data: in_byte};
        push_cnt = accept ? ({1'b0, emit_byte} + {1'b0, emit_final}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            match_pos_reg <= '0;
            line_pos_reg  <= '0;
            prev_byte_reg <= '0;
            finished_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            match_pos_reg <= match_pos_next;
            line_pos_reg  <= line_pos_next;
            prev_byte_reg <= prev_byte_next;
            finished_reg  <= finished_next;
        end
    end

    // output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
    end

endmodule

[rtl/core/hfve_checker.sv]
// Port-level checker for the header field value extractor, with its bind.
module hfve_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] out_kind,
    input  logic [7:0] out_byte
);
    import hfve_pkg::*;

    // only the three defined result kinds appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == KIND_BYTE) || (out_kind == KIND_FOUND) ||
                      (out_kind == KIND_NOT_FOUND))
        else $error("undefined result kind");

    // status results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind != KIND_BYTE)) |-> (out_byte == 8'h00))
        else $error("status result with nonzero byte");

    // input only backs up behind pending results
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // a stalled transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_byte)))
        else $error("stalled output changed");

endmodule

bind header_field_value_extractor hfve_checker u_hfve_checker (.*);
